@@ rtl/core/rc4_pkg.sv @@
package rc4_pkg;

  localparam int BYTE_W      = 8;
  localparam int KEY_LEN_W   = 9;
  localparam int TABLE_DEPTH = 256;
  localparam int MAX_KEY_LEN = 256;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int KEY_AW      = $clog2(MAX_KEY_LEN);

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX   = KEY_LEN_W'(MAX_KEY_LEN);

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ACC_KEY,
    DP_ACC_DATA,
    DP_INIT,
    DP_KS_RD,
    DP_KS_J,
    DP_KS_WK,
    DP_KS_WJ,
    DP_D_RI,
    DP_D_RJ,
    DP_D_WI,
    DP_D_WJ,
    DP_D_RT,
    DP_D_OUT,
    DP_PASS
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic sched_hit;
    logic k_last;
    logic keyed;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/core/rc4_if.sv @@
interface rc4_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [rc4_pkg::BYTE_W-1:0]  in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface rc4_out_if;
  logic                        valid;
  logic                        ready;
  logic [rc4_pkg::BYTE_W-1:0]  out_byte;
  logic                        keyed;

  modport source (output valid, output out_byte, output keyed, input ready);
  modport sink   (input valid, input out_byte, input keyed, output ready);
endinterface

@@ rtl/core/rc4_ctrl.sv @@
module rc4_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  input  rc4_pkg::dp_stat_t  stat,
  output rc4_pkg::dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WK,
    ST_KS_WJ,
    ST_D_RI,
    ST_D_RJ,
    ST_D_WI,
    ST_D_WJ,
    ST_D_RT,
    ST_D_OUT,
    ST_PASS
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = rc4_pkg::DP_NOP;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == rc4_pkg::OP_KEY) begin
            cmd.op = rc4_pkg::DP_ACC_KEY;
            if (stat.sched_hit) state_nxt = ST_INIT;
          end else begin
            cmd.op    = rc4_pkg::DP_ACC_DATA;
            state_nxt = stat.keyed ? ST_D_RI : ST_PASS;
          end
        end
      end
      ST_INIT: begin
        cmd.op = rc4_pkg::DP_INIT;
        if (stat.k_last) state_nxt = ST_KS_RD;
      end
      ST_KS_RD: begin
        cmd.op    = rc4_pkg::DP_KS_RD;
        state_nxt = ST_KS_J;
      end
      ST_KS_J: begin
        cmd.op    = rc4_pkg::DP_KS_J;
        state_nxt = ST_KS_WK;
      end
      ST_KS_WK: begin
        cmd.op    = rc4_pkg::DP_KS_WK;
        state_nxt = ST_KS_WJ;
      end
      ST_KS_WJ: begin
        cmd.op    = rc4_pkg::DP_KS_WJ;
        state_nxt = stat.k_last ? ST_IDLE : ST_KS_RD;
      end
      ST_D_RI: begin
        cmd.op    = rc4_pkg::DP_D_RI;
        state_nxt = ST_D_RJ;
      end
      ST_D_RJ: begin
        cmd.op    = rc4_pkg::DP_D_RJ;
        state_nxt = ST_D_WI;
      end
      ST_D_WI: begin
        cmd.op    = rc4_pkg::DP_D_WI;
        state_nxt = ST_D_WJ;
      end
      ST_D_WJ: begin
        cmd.op    = rc4_pkg::DP_D_WJ;
        state_nxt = ST_D_RT;
      end
      ST_D_RT: begin
        cmd.op    = rc4_pkg::DP_D_RT;
        state_nxt = ST_D_OUT;
      end
      ST_D_OUT: begin
        if (stat.out_free) begin
          cmd.op    = rc4_pkg::DP_D_OUT;
          state_nxt = ST_IDLE;
        end
      end
      ST_PASS: begin
        if (stat.out_free) begin
          cmd.op    = rc4_pkg::DP_PASS;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/rc4_dp.sv @@
module rc4_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [rc4_pkg::KEY_LEN_W-1:0]     key_length,
  input  logic [rc4_pkg::BYTE_W-1:0]        in_byte,
  input  rc4_pkg::dp_cmd_t                  cmd,
  output rc4_pkg::dp_stat_t                 stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rc4_pkg::BYTE_W-1:0]        out_byte,
  output logic                              out_keyed
);

  logic [rc4_pkg::BYTE_W-1:0] perm_mem [rc4_pkg::TABLE_DEPTH];
  logic [rc4_pkg::BYTE_W-1:0] key_mem  [rc4_pkg::MAX_KEY_LEN];

  logic [rc4_pkg::KEY_LEN_W-1:0] key_count_r, key_count_nxt;
  logic [rc4_pkg::TABLE_AW-1:0]  k_r, k_nxt;
  logic [rc4_pkg::KEY_AW-1:0]    kidx_r, kidx_nxt;
  logic [rc4_pkg::TABLE_AW-1:0]  i_r, i_nxt;
  logic [rc4_pkg::TABLE_AW-1:0]  j_r, j_nxt;
  logic [rc4_pkg::BYTE_W-1:0]    sa_r, sa_nxt;
  logic [rc4_pkg::TABLE_AW-1:0]  t_r, t_nxt;
  logic [rc4_pkg::BYTE_W-1:0]    byte_r, byte_nxt;
  logic                          keyed_r, keyed_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rc4_pkg::BYTE_W-1:0]    out_byte_r, out_byte_nxt;
  logic                          out_keyed_r, out_keyed_nxt;

  logic [rc4_pkg::BYTE_W-1:0]    perm_rd_r;
  logic [rc4_pkg::BYTE_W-1:0]    key_rd_r;

  logic                          perm_we, perm_re, key_we, key_re;
  logic [rc4_pkg::TABLE_AW-1:0]  perm_waddr, perm_raddr;
  logic [rc4_pkg::BYTE_W-1:0]    perm_wdata;

  logic [rc4_pkg::KEY_LEN_W-1:0] eff_len;
  logic [rc4_pkg::KEY_LEN_W-1:0] count_inc;
  logic [rc4_pkg::KEY_LEN_W-1:0] kidx_inc;
  logic [rc4_pkg::TABLE_AW-1:0]  j_ks;
  logic [rc4_pkg::TABLE_AW-1:0]  j_data;
  logic [rc4_pkg::TABLE_AW-1:0]  i_inc;
  logic                          out_free;

  // zero acts as one, anything above the store depth as the full depth
  always_comb begin
    if (key_length == '0) begin
      eff_len = rc4_pkg::KEY_LEN_W'(1);
    end else if (key_length > rc4_pkg::KEY_LEN_MAX) begin
      eff_len = rc4_pkg::KEY_LEN_MAX;
    end else begin
      eff_len = key_length;
    end
  end

  assign count_inc = key_count_r + rc4_pkg::KEY_LEN_W'(1);
  assign kidx_inc  = {{(rc4_pkg::KEY_LEN_W-rc4_pkg::KEY_AW){1'b0}}, kidx_r}
                     + rc4_pkg::KEY_LEN_W'(1);
  assign j_ks      = j_r + perm_rd_r + key_rd_r;
  assign j_data    = j_r + perm_rd_r;
  assign i_inc     = i_r + rc4_pkg::TABLE_AW'(1);
  assign out_free  = !out_valid_r || out_ready;

  assign stat.sched_hit = (count_inc >= eff_len);
  assign stat.k_last    = (k_r == {rc4_pkg::TABLE_AW{1'b1}});
  assign stat.keyed     = keyed_r;
  assign stat.out_free  = out_free;

  always_comb begin
    key_count_nxt = key_count_r;
    k_nxt         = k_r;
    kidx_nxt      = kidx_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    sa_nxt        = sa_r;
    t_nxt         = t_r;
    byte_nxt      = byte_r;
    keyed_nxt     = keyed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_keyed_nxt = out_keyed_r;
    perm_we       = 1'b0;
    perm_re       = 1'b0;
    key_we        = 1'b0;
    key_re        = 1'b0;
    perm_waddr    = k_r;
    perm_wdata    = k_r;
    perm_raddr    = k_r;
    case (cmd.op)
      rc4_pkg::DP_ACC_KEY: begin
        key_we = 1'b1;
        if (stat.sched_hit) begin
          key_count_nxt = '0;
          k_nxt         = '0;
        end else begin
          key_count_nxt = count_inc;
        end
      end
      rc4_pkg::DP_ACC_DATA: begin
        byte_nxt = in_byte;
      end
      rc4_pkg::DP_INIT: begin
        perm_we = 1'b1;
        k_nxt   = k_r + rc4_pkg::TABLE_AW'(1);
        kidx_nxt = '0;
        j_nxt   = '0;
      end
      rc4_pkg::DP_KS_RD: begin
        perm_re    = 1'b1;
        key_re     = 1'b1;
        perm_raddr = k_r;
      end
      rc4_pkg::DP_KS_J: begin
        perm_re    = 1'b1;
        perm_raddr = j_ks;
        j_nxt      = j_ks;
        sa_nxt     = perm_rd_r;
      end
      rc4_pkg::DP_KS_WK: begin
        perm_we    = 1'b1;
        perm_waddr = k_r;
        perm_wdata = perm_rd_r;
      end
      rc4_pkg::DP_KS_WJ: begin
        perm_we    = 1'b1;
        perm_waddr = j_r;
        perm_wdata = sa_r;
        k_nxt      = k_r + rc4_pkg::TABLE_AW'(1);
        kidx_nxt   = (kidx_inc >= eff_len) ? '0 : kidx_inc[rc4_pkg::KEY_AW-1:0];
        if (stat.k_last) begin
          i_nxt     = '0;
          j_nxt     = '0;
          keyed_nxt = 1'b1;
        end
      end
      rc4_pkg::DP_D_RI: begin
        perm_re    = 1'b1;
        perm_raddr = i_inc;
        i_nxt      = i_inc;
      end
      rc4_pkg::DP_D_RJ: begin
        perm_re    = 1'b1;
        perm_raddr = j_data;
        j_nxt      = j_data;
        sa_nxt     = perm_rd_r;
      end
      rc4_pkg::DP_D_WI: begin
        perm_we    = 1'b1;
        perm_waddr = i_r;
        perm_wdata = perm_rd_r;
        t_nxt      = sa_r + perm_rd_r;
      end
      rc4_pkg::DP_D_WJ: begin
        perm_we    = 1'b1;
        perm_waddr = j_r;
        perm_wdata = sa_r;
      end
      rc4_pkg::DP_D_RT: begin
        perm_re    = 1'b1;
        perm_raddr = t_r;
      end
      rc4_pkg::DP_D_OUT: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = perm_rd_r ^ byte_r;
        out_keyed_nxt = 1'b1;
      end
      rc4_pkg::DP_PASS: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = byte_r;
        out_keyed_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    if (perm_re) begin
      perm_rd_r <= perm_mem[perm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count_r[rc4_pkg::KEY_AW-1:0]] <= in_byte;
    end
    if (key_re) begin
      key_rd_r <= key_mem[kidx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
      i_r         <= '0;
      j_r         <= '0;
      keyed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      key_count_r <= key_count_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      keyed_r     <= keyed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    kidx_r      <= kidx_nxt;
    sa_r        <= sa_nxt;
    t_r         <= t_nxt;
    byte_r      <= byte_nxt;
    out_byte_r  <= out_byte_nxt;
    out_keyed_r <= out_keyed_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_keyed = out_keyed_r;

endmodule

@@ rtl/core/rc4_stream_cipher_unit.sv @@
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   op (0 key byte, 1 data byte), in_byte[7:0]
// out_ch    out  valid/ready   out_byte[7:0], keyed
// cfg       in   cfg_we        cfg_wdata[8:0] = key_length
//
// A key byte is taken in the idle state; the byte that completes the key adds
// a schedule: table init of all 256 entries, then 256 steps of KS_RD, KS_J,
// KS_WK and KS_WJ. A data byte is taken, then passes five permutation memory
// accesses and the output state; unkeyed bytes go straight to ST_PASS.
// Synchronous active-low reset; no clearing pass, the table is rebuilt by each
// schedule. One request is in flight; the output register holds a result while
// the next request is taken, and a stalled output stalls only the final state.
module rc4_stream_cipher_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  rc4_in_if.sink                         in_ch,
  rc4_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rc4_pkg::KEY_LEN_W-1:0]  cfg_wdata
);

  logic [rc4_pkg::KEY_LEN_W-1:0] key_length_r;
  rc4_pkg::dp_cmd_t              cmd;
  rc4_pkg::dp_stat_t             stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= rc4_pkg::KEY_LEN_RESET;
    end else if (cfg_we) begin
      key_length_r <= cfg_wdata;
    end
  end

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rc4_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_length (key_length_r),
    .in_byte    (in_ch.in_byte),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .out_keyed  (out_ch.keyed)
  );

endmodule

@@ dv/rc4_stream_cipher_unit_tb.sv @@
module rc4_stream_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCHED_SETTLE   = 1400;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_HOLD      = 400;

  typedef struct packed {
    logic                       op;
    logic [rc4_pkg::BYTE_W-1:0] data;
  } cipher_req_t;

  typedef struct packed {
    logic [rc4_pkg::BYTE_W-1:0] data;
    logic                       keyed;
  } cipher_out_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we;
  logic [rc4_pkg::KEY_LEN_W-1:0] cfg_wdata;

  rc4_in_if  in_ch();
  rc4_out_if out_ch();

  rc4_stream_cipher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  cipher_req_t pending_reqs[$];
  cipher_out_t expected_out[$];
  cipher_req_t drv_req;
  cipher_out_t exp_res;
  int unsigned n_queued, n_accepted, n_errors;
  int unsigned in_gap, out_gap, idle_cycles;
  logic        no_idle, hold_req, hold_started, last_was_key;

  // cipher state mirror
  logic [rc4_pkg::BYTE_W-1:0]    s_box [rc4_pkg::TABLE_DEPTH];
  logic [rc4_pkg::BYTE_W-1:0]    key_bytes [rc4_pkg::MAX_KEY_LEN];
  logic [rc4_pkg::KEY_LEN_W-1:0] key_fill;
  logic [rc4_pkg::KEY_LEN_W-1:0] key_len_cfg;
  logic [rc4_pkg::BYTE_W-1:0]    ks_i, ks_j;
  logic                          ks_ready;

  function automatic int unsigned eff_key_len(logic [rc4_pkg::KEY_LEN_W-1:0] v);
    if (v == '0) return 1;
    if (v > rc4_pkg::KEY_LEN_MAX) return rc4_pkg::MAX_KEY_LEN;
    return 32'(v);
  endfunction

  task automatic rc4_predict(cipher_req_t r);
    int unsigned                len;
    logic [rc4_pkg::BYTE_W-1:0] j;
    logic [rc4_pkg::BYTE_W-1:0] t;
    if (r.op == rc4_pkg::OP_KEY) begin
      len = eff_key_len(key_len_cfg);
      if (32'(key_fill) < rc4_pkg::MAX_KEY_LEN) begin
        key_bytes[key_fill[rc4_pkg::KEY_AW-1:0]] = r.data;
      end
      key_fill = key_fill + rc4_pkg::KEY_LEN_W'(1);
      if (32'(key_fill) >= len) begin
        for (int k = 0; k < rc4_pkg::TABLE_DEPTH; k++) s_box[k] = k[rc4_pkg::BYTE_W-1:0];
        j = '0;
        for (int k = 0; k < rc4_pkg::TABLE_DEPTH; k++) begin
          j = j + s_box[k] + key_bytes[k % len];
          t = s_box[k];
          s_box[k] = s_box[j];
          s_box[j] = t;
        end
        ks_i = '0;
        ks_j = '0;
        ks_ready = 1'b1;
        key_fill = '0;
      end
    end else if (!ks_ready) begin
      expected_out.push_back('{data: r.data, keyed: 1'b0});
    end else begin
      ks_i = ks_i + rc4_pkg::BYTE_W'(1);
      ks_j = ks_j + s_box[ks_i];
      t = s_box[ks_i];
      s_box[ks_i] = s_box[ks_j];
      s_box[ks_j] = t;
      t = s_box[ks_i] + s_box[ks_j];
      expected_out.push_back('{data: s_box[t] ^ r.data, keyed: 1'b1});
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 17);
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        drv_req = pending_reqs.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.op      <= drv_req.op;
        in_ch.in_byte <= drv_req.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      rc4_predict('{op: in_ch.op, data: in_ch.in_byte});
      n_accepted++;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_out.size() == 0) begin
          $error("unexpected result: out_byte %0h keyed %0b", out_ch.out_byte, out_ch.keyed);
          n_errors++;
        end else begin
          exp_res = expected_out.pop_front();
          if (out_ch.out_byte !== exp_res.data) begin
            $error("out_byte: expected %0h, got %0h", exp_res.data, out_ch.out_byte);
            n_errors++;
          end
          if (out_ch.keyed !== exp_res.keyed) begin
            $error("keyed: expected %0b, got %0b", exp_res.keyed, out_ch.keyed);
            n_errors++;
          end
        end
      end
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        out_gap = LONG_HOLD;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 17);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  task automatic push_req(logic op, logic [rc4_pkg::BYTE_W-1:0] data);
    pending_reqs.push_back('{op: op, data: data});
    n_queued++;
    last_was_key = (op == rc4_pkg::OP_KEY);
  endtask

  task automatic push_data(int n);
    repeat (n) push_req(rc4_pkg::OP_DATA, rc4_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // key bytes with a data request slipped in now and then
  task automatic push_key(int n);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        push_req(rc4_pkg::OP_DATA, rc4_pkg::BYTE_W'($urandom_range(0, 255)));
      end
      push_req(rc4_pkg::OP_KEY, rc4_pkg::BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // all requests taken, all results seen, schedule given time to finish
  task automatic wait_idle();
    do @(posedge clk); while (n_accepted != n_queued || expected_out.size() != 0);
    repeat (last_was_key ? SCHED_SETTLE : 20) @(posedge clk);
  endtask

  task automatic write_key_len(logic [rc4_pkg::KEY_LEN_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_len_cfg = v;
  endtask

  initial begin
    int unsigned rand_end;
    int unsigned len;
    int          rem;
    int unsigned pick;

    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.op      = rc4_pkg::OP_KEY;
    in_ch.in_byte = '0;
    out_ch.ready  = 1'b0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    hold_started  = 1'b0;
    last_was_key  = 1'b0;
    n_queued      = 0;
    n_accepted    = 0;
    n_errors      = 0;
    idle_cycles   = 0;
    for (int k = 0; k < rc4_pkg::TABLE_DEPTH; k++) s_box[k] = k[rc4_pkg::BYTE_W-1:0];
    for (int k = 0; k < rc4_pkg::MAX_KEY_LEN; k++) key_bytes[k] = '0;
    key_fill    = '0;
    key_len_cfg = rc4_pkg::KEY_LEN_RESET;
    ks_i        = '0;
    ks_j        = '0;
    ks_ready    = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // unkeyed pass-through
    push_req(rc4_pkg::OP_DATA, 8'h00);
    push_req(rc4_pkg::OP_DATA, 8'hFF);
    // partial load, then length cut to the count
    push_req(rc4_pkg::OP_KEY, 8'h00);
    push_req(rc4_pkg::OP_KEY, 8'hFF);
    write_key_len(9'd2);
    push_req(rc4_pkg::OP_KEY, 8'h5A);
    push_req(rc4_pkg::OP_DATA, 8'h00);
    push_req(rc4_pkg::OP_DATA, 8'hFF);
    push_req(rc4_pkg::OP_DATA, 8'h80);
    push_req(rc4_pkg::OP_DATA, 8'h01);
    // zero length acts as one
    write_key_len(9'd0);
    push_req(rc4_pkg::OP_KEY, 8'hFF);
    push_req(rc4_pkg::OP_DATA, 8'h00);
    push_req(rc4_pkg::OP_DATA, 8'hFF);
    // rekey while keyed: old stream until the new key completes
    write_key_len(9'd3);
    push_req(rc4_pkg::OP_KEY, 8'h01);
    push_req(rc4_pkg::OP_DATA, 8'h7F);
    push_req(rc4_pkg::OP_KEY, 8'h02);
    push_req(rc4_pkg::OP_KEY, 8'h03);
    push_req(rc4_pkg::OP_DATA, 8'hAA);
    write_key_len(9'd1);
    push_req(rc4_pkg::OP_KEY, 8'h00);
    push_req(rc4_pkg::OP_DATA, 8'h33);

    // longest key, length raised past the max mid-load
    write_key_len(rc4_pkg::KEY_LEN_MAX);
    push_key(100);
    push_data(5);
    write_key_len(9'd511);
    wait_idle();
    push_key(int'(eff_key_len(key_len_cfg) - 32'(key_fill)));
    push_data(10);

    rand_end = n_queued + 40;
    while (n_queued < rand_end) begin
      if ($urandom_range(0, 3) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) write_key_len(9'd0);
        else if (pick < 4) write_key_len(rc4_pkg::KEY_LEN_W'($urandom_range(17, 64)));
        else write_key_len(rc4_pkg::KEY_LEN_W'($urandom_range(1, 16)));
      end else begin
        wait_idle();
      end
      len = eff_key_len(key_len_cfg);
      rem = (len > 32'(key_fill)) ? int'(len - 32'(key_fill)) : 1;
      if (rem > 1 && $urandom_range(0, 4) == 0) push_key($urandom_range(1, rem - 1));
      else push_key(rem);
      push_data($urandom_range(1, 20));
    end

    // receiver holds off while data keeps coming
    write_key_len(9'd8);
    push_key(8);
    push_data(5);
    wait_idle();
    hold_req = 1'b1;
    push_data(40);

    wait_idle();
    no_idle = 1'b1;
    write_key_len(9'd5);
    push_key(5);
    push_data(30);

    wait_idle();
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
